/* hdl/refcounted_sorted_value_table_defines.svh */
// Assertion macros shared by the table RTL.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef REFCOUNTED_SORTED_VALUE_TABLE_DEFINES_SVH
`define REFCOUNTED_SORTED_VALUE_TABLE_DEFINES_SVH

// same-cycle implication
`define RSVT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rsvt_pkg.sv */
// Types and constants of the sorted value table.
// No dependencies; used by rsvt_cell and refcounted_sorted_value_table.
package rsvt_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_INCR,
        OP_DECR,
        OP_REMOVE
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_INCREMENTED = 3'd1,
        ST_DECREMENTED = 3'd2,
        ST_REMOVED     = 3'd3,
        ST_NOT_FOUND   = 3'd4,
        ST_FULL_OR_SAT = 3'd5
    } status_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } entry_t;

endpackage

/* hdl/rsvt_cell.sv */
// One table cell: holds an entry, compares it to the key, shifts with neighbors.
// Depends on rsvt_pkg.
module rsvt_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rsvt_pkg::cell_ctrl_t        ctrl,
    input  logic signed [31:0]          key,
    input  rsvt_pkg::entry_t            prev_entry,
    input  rsvt_pkg::entry_t            next_entry,
    input  logic                        prev_lt,
    output rsvt_pkg::entry_t            entry,
    output logic                        lt,
    output logic                        eq,
    output logic                        at_pos
);
    import rsvt_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic                      lt_reg;
    logic                      lt_next;
    logic                      eq_reg;
    logic                      eq_next;

    assign entry  = '{valid: valid_reg, value: value_reg, count: count_reg};
    assign lt     = lt_reg;
    assign eq     = eq_reg;
    assign at_pos = !lt_reg && prev_lt;

    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctrl.cmp_en)
        begin
            lt_next = valid_reg && (value_reg < key);
            eq_next = valid_reg && (value_reg == key);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        count_next = count_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (at_pos)
                begin
                    valid_next = 1'b1;
                    value_next = key;
                    count_next = COUNT_W'(1);
                end
                else if (!lt_reg)
                begin
                    valid_next = prev_entry.valid;
                    value_next = prev_entry.value;
                    count_next = prev_entry.count;
                end
            end
            OP_INCR:
            begin
                if (eq_reg)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_DECR:
            begin
                if (eq_reg)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (!lt_reg)
                begin
                    valid_next = next_entry.valid;
                    value_next = next_entry.value;
                    count_next = next_entry.count;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        count_reg <= count_next;
    end

endmodule

/* hdl/refcounted_sorted_value_table.sv */
// Reference-counted sorted value table, top level.
// Depends on rsvt_pkg, rsvt_cell and refcounted_sorted_value_table_defines.svh.
//
// Usage:
//   Request channel: start, kind, value. An item is taken at a rising edge
//   with start high and busy low. kind 0 adds a reference, kind 1 drops one.
//   Result channel: done strobes for one cycle with status, ref_total, slot
//   and entries_used. The receiver cannot stall; every result must be taken.
// Timing:
//   Compare step, cmp_reg high: every cell compares its entry with the key.
//   Update step, upd_reg high: the row shifts, inserts or updates a count in
//   one step, and the result registers load; done is high in the cycle that
//   follows. busy is high for one cycle after each accept, so a new item can
//   be taken in the update step of the one before, ahead of its done. Each
//   item makes one compare-then-shift pass over the cell row.
// Reset:
//   rst_n clears every cell's valid bit and the occupancy count; the table
//   is empty and ready at once, no clearing pass needed.
`include "refcounted_sorted_value_table_defines.svh"

module refcounted_sorted_value_table #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               kind,
    input  logic signed [31:0] value,
    output logic               busy,
    output logic               done,
    output logic [2:0]         status,
    output logic [15:0]        ref_total,
    output logic [5:0]         slot,
    output logic [6:0]         entries_used
);
    import rsvt_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);

    logic                      cmp_reg;
    logic                      upd_reg;
    logic                      kind_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic [OCC_W-1:0]          occ_reg;
    logic [OCC_W-1:0]          occ_next;
    logic                      done_reg;
    status_t                   status_reg;
    status_t                   status_next;
    logic [COUNT_W-1:0]        total_reg;
    logic [COUNT_W-1:0]        total_next;
    logic [5:0]                slot_reg;
    logic [5:0]                slot_next;

    cell_ctrl_t                ctrl;
    entry_t                    cell_entry [DEPTH];
    logic [DEPTH-1:0]          cell_lt;
    logic [DEPTH-1:0]          cell_eq;
    logic [DEPTH-1:0]          cell_at_pos;

    logic                      accept;
    logic                      found;
    logic                      full;
    logic [COUNT_W-1:0]        hit_count;
    logic [31:0]               pos_idx;

    assign accept = start && !busy;
    assign busy   = cmp_reg;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            entry_t prev_e;
            entry_t next_e;
            logic   prev_l;
            if (g == 0)
            begin : g_first
                assign prev_e = '0;
                assign prev_l = 1'b1;
            end
            else
            begin : g_mid
                assign prev_e = cell_entry[g-1];
                assign prev_l = cell_lt[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign next_e = '0;
            end
            else
            begin : g_inner
                assign next_e = cell_entry[g+1];
            end
            rsvt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (key_reg),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .prev_lt    (prev_l),
                .entry      (cell_entry[g]),
                .lt         (cell_lt[g]),
                .eq         (cell_eq[g]),
                .at_pos     (cell_at_pos[g])
            );
        end
    endgenerate

    assign found = |cell_eq;
    assign full  = (occ_reg == OCC_W'(DEPTH));

    always_comb
    begin
        hit_count = '0;
        pos_idx   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_count = hit_count | (cell_eq[i] ? cell_entry[i].count : '0);
            pos_idx   = pos_idx | (cell_at_pos[i] ? 32'(i) : 32'd0);
        end
    end

    always_comb
    begin
        ctrl.cmp_en = cmp_reg;
        ctrl.op     = OP_HOLD;
        status_next = ST_NOT_FOUND;
        total_next  = '0;
        slot_next   = '0;
        occ_next    = occ_reg;
        if (upd_reg)
        begin
            if (!kind_reg)
            begin
                if (found)
                begin
                    slot_next = pos_idx[5:0];
                    if (hit_count == COUNT_MAX)
                    begin
                        status_next = ST_FULL_OR_SAT;
                        total_next  = COUNT_MAX;
                    end
                    else
                    begin
                        ctrl.op     = OP_INCR;
                        status_next = ST_INCREMENTED;
                        total_next  = hit_count + COUNT_W'(1);
                    end
                end
                else if (full)
                begin
                    status_next = ST_FULL_OR_SAT;
                end
                else
                begin
                    ctrl.op     = OP_INSERT;
                    status_next = ST_INSERTED;
                    total_next  = COUNT_W'(1);
                    slot_next   = pos_idx[5:0];
                    occ_next    = occ_reg + OCC_W'(1);
                end
            end
            else if (found)
            begin
                slot_next = pos_idx[5:0];
                if (hit_count == COUNT_W'(1))
                begin
                    ctrl.op     = OP_REMOVE;
                    status_next = ST_REMOVED;
                    occ_next    = occ_reg - OCC_W'(1);
                end
                else
                begin
                    ctrl.op     = OP_DECR;
                    status_next = ST_DECREMENTED;
                    total_next  = hit_count - COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_reg  <= 1'b0;
            upd_reg  <= 1'b0;
            done_reg <= 1'b0;
            occ_reg  <= '0;
        end
        else
        begin
            cmp_reg  <= accept;
            upd_reg  <= cmp_reg;
            done_reg <= upd_reg;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            key_reg  <= value;
        end
        if (upd_reg)
        begin
            status_reg <= status_next;
            total_reg  <= total_next;
            slot_reg   <= slot_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign ref_total    = total_reg;
    assign slot         = slot_reg;
    assign entries_used = 7'(32'(occ_reg));

    `RSVT_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= OCC_W'(DEPTH), "occupancy above depth")
    `RSVT_ASSERT_NEXT(a_cmp_then_upd, cmp_reg, upd_reg && !cmp_reg, "compare not followed by update")
    `RSVT_ASSERT_NEXT(a_insert_grows, upd_reg && ctrl.op == OP_INSERT,
        occ_reg == $past(occ_reg) + OCC_W'(1), "insert did not grow occupancy")
    `RSVT_ASSERT_NOW(a_eq_onehot, upd_reg, $onehot0(cell_eq), "key matched more than one cell")
    `RSVT_ASSERT_NOW(a_not_found_zero, done && status == ST_NOT_FOUND,
        ref_total == '0 && slot == '0, "not found result carries data")

endmodule
